// ===== sv/percent_decode_stream_defines.svh =====
// Assertion macros shared by the percent decoder checker.
`ifndef PERCENT_DECODE_STREAM_DEFINES_SVH
`define PERCENT_DECODE_STREAM_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PDEC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("percent decoder check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PDEC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("percent decoder check failed");

`endif

// ===== sv/pdec_pkg.sv =====
// Package: types, character codes and hex digit conversion for the percent decoder.
`timescale 1ns / 1ps

package pdec_pkg;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_PCT     = 8'h25; // '%'
   localparam logic [7:0] CHAR_TWO     = 8'h32; // '2'
   localparam logic [7:0] CHAR_FIVE    = 8'h35; // '5'
   localparam logic [7:0] CHAR_COLON   = 8'h3A; // ':'
   localparam logic [7:0] CHAR_AT      = 8'h40; // '@'
   localparam logic [7:0] CHAR_LBRACK  = 8'h5B; // '['
   localparam logic [7:0] DIGIT_BASE   = 8'd48;
   localparam logic [7:0] UPPER_BASE   = 8'd55; // 'A' - 10
   localparam logic [7:0] LOWER_BASE   = 8'd87; // 'a' - 10
   localparam logic [15:0] LEN_MAX     = 16'hFFFF;
   localparam logic [15:0] CAP_MIN     = 16'd2;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_PCT  = 3'd1,
      PH_TWO  = 3'd2,
      PH_HI   = 3'd3,
      PH_LO   = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        done_res;
      logic [15:0] out_length;
   } rsp_type;

   // Any byte maps to a digit value, wrapping at 8 bits; a non-hex low digit
   // carries into the high nibble of the decoded byte.
   function automatic logic [7:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c < CHAR_COLON) begin
         v = c - DIGIT_BASE;
      end else if (c > CHAR_AT && c < CHAR_LBRACK) begin
         v = c - UPPER_BASE;
      end else begin
         v = c - LOWER_BASE;
      end
      return v;
   endfunction

endpackage

// ===== sv/percent_decode_stream.sv =====
// Top level: streaming URL percent-escape decoder with one output register.
// A result is registered and appears on rsp_ in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; the only back-pressure is a held output register.
// Escape state, count and discard flag update in the cycle a byte is taken.
// Reset is synchronous, active high: clears state, empties the output, max_size to 0.
`timescale 1ns / 1ps

module percent_decode_stream
   import pdec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  high_ff, high_in;
   logic [15:0] count_ff, count_in;
   logic        discard_ff, discard_in;
   logic [15:0] max_size_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [7:0]  c;
   logic        last;
   logic [7:0]  lo;
   logic        active;
   logic        is_zero;
   logic        emit_now;
   logic        hold;
   logic [15:0] cnt_inc;
   logic        cap_hit;
   logic        res_valid;
   logic        res_done;
   logic        string_end;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign c       = req_data.in_byte;
   assign last    = req_data.in_last;
   assign lo      = hex_value(c);
   assign active  = accept & ~discard_ff;
   assign is_zero = (c == CHAR_NUL);

   assign cnt_inc = (count_ff == LEN_MAX) ? count_ff : count_ff + 16'd1;
   assign cap_hit = (max_size_ff >= CAP_MIN) && (cnt_inc == max_size_ff - 16'd1);

   // Byte that closes a character: plain byte, "%2" + non-'5', or low digit.
   always_comb begin
      case (phase_ff)
         PH_IDLE: emit_now = (c != CHAR_PCT);
         PH_PCT:  emit_now = 1'b0;
         PH_TWO:  emit_now = (c != CHAR_FIVE);
         PH_HI:   emit_now = 1'b0;
         default: emit_now = 1'b1;
      endcase
   end

   assign hold       = active & ~is_zero & ~emit_now;
   assign res_valid  = active & (is_zero | emit_now | last);
   assign res_done   = (active & ~is_zero & emit_now) ? (last | cap_hit) : 1'b1;
   assign string_end = res_valid & res_done;

   // Next state
   always_comb begin
      phase_in   = phase_ff;
      high_in    = high_ff;
      count_in   = count_ff;
      discard_in = discard_ff;
      if (accept && discard_ff) begin
         if (last) begin
            discard_in = 1'b0;
         end
      end else if (string_end) begin
         phase_in   = PH_IDLE;
         high_in    = 4'd0;
         count_in   = 16'd0;
         discard_in = ~last;
      end else if (active && emit_now) begin
         phase_in = PH_IDLE;
         count_in = cnt_inc;
      end else if (hold) begin
         case (phase_ff)
            PH_IDLE: phase_in = PH_PCT;
            PH_PCT: begin
               if (c == CHAR_TWO) begin
                  phase_in = PH_TWO;
               end else begin
                  phase_in = PH_LO;
                  high_in  = lo[3:0];
               end
            end
            PH_TWO: phase_in = PH_HI;
            PH_HI: begin
               phase_in = PH_LO;
               high_in  = lo[3:0];
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Result transaction
   always_comb begin
      rsp_data_in.byte_valid = active & ~is_zero & emit_now;
      rsp_data_in.done_res   = res_done;
      rsp_data_in.out_length = rsp_data_in.byte_valid ? cnt_inc : count_ff;
      rsp_data_in.out_byte   = 8'd0;
      if (rsp_data_in.byte_valid) begin
         case (phase_ff)
            PH_IDLE: rsp_data_in.out_byte = c;
            PH_TWO:  rsp_data_in.out_byte = {4'h2, 4'h0} + lo;
            default: rsp_data_in.out_byte = {high_ff, 4'h0} + lo;
         endcase
      end
   end

   assign rsp_valid_in = res_valid | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         high_ff      <= 4'd0;
         count_ff     <= 16'd0;
         discard_ff   <= 1'b0;
         max_size_ff  <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         high_ff      <= high_in;
         count_ff     <= count_in;
         discard_ff   <= discard_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_size_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/pdec_checker.sv =====
// Checker for the percent decoder ports, bound to the top level.
`timescale 1ns / 1ps
`include "percent_decode_stream_defines.svh"

module pdec_checker
   import pdec_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input req_type     req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rsp_type     rsp_data,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [15:0] csr_data
);

   logic unused_ok;
   assign unused_ok = req_valid ^ req_stall ^ (^req_data) ^ csr_valid ^ csr_ready ^ (^csr_data);

   `PDEC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `PDEC_ASSERT_IMP(a_empty_is_done, clock, reset, rsp_valid && !rsp_data.byte_valid, rsp_data.done_res)
   `PDEC_ASSERT_IMP(a_empty_is_zero, clock, reset, rsp_valid && !rsp_data.byte_valid, rsp_data.out_byte == 8'd0)
   `PDEC_ASSERT_IMP(a_len_counts, clock, reset, rsp_valid && rsp_data.byte_valid, rsp_data.out_length != 16'd0)

endmodule

bind percent_decode_stream pdec_checker u_pdec_checker (.*);

// ===== tb/testbench.sv =====
// Testbench for percent_decode_stream: random URL frames checked against a decoder model.
`timescale 1ns / 1ps

module testbench;
   import pdec_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_ITEMS  = 185;
   localparam int PHASES       = 7;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data  = '0;

   // no idling on either side while set
   bit          calm      = 1'b0;
   req_type     url_q[$];

   class decode_scoreboard;
      rsp_type     decoded_q[$];
      logic [15:0] cap_size;
      phase_type   phase;
      logic [7:0]  high_digit;
      logic [15:0] char_count;
      bit          skipping;
      int          errors;
      int          bytes_taken;
      int          results_checked;
      int          strings_ended;
      int          caps_written;

      function new();
         cap_size   = '0;
         phase      = PH_IDLE;
         high_digit = '0;
         char_count = '0;
         skipping   = 1'b0;
      endfunction

      function int pending();
         return decoded_q.size();
      endfunction

      function void set_cap(logic [15:0] v);
         cap_size = v;
         caps_written++;
      endfunction

      // any byte maps to a digit value; the arithmetic wraps at 8 bits
      function logic [7:0] digit_value(logic [7:0] c);
         if (c < CHAR_COLON) begin
            return c - 8'd48;
         end else if (c > CHAR_AT && c < CHAR_LBRACK) begin
            return c - 8'd55;
         end else begin
            return c - 8'd87;
         end
      endfunction

      function void finish_string(bit last);
         phase      = PH_IDLE;
         high_digit = '0;
         char_count = '0;
         skipping   = !last;
      endfunction

      function void push_result(logic [7:0] b, bit valid, bit done);
         rsp_type r;
         r.out_byte   = b;
         r.byte_valid = valid;
         r.done_res   = done;
         r.out_length = char_count;
         decoded_q.push_back(r);
      endfunction

      function void emit_char(logic [7:0] b, bit last);
         bit done;
         if (char_count != LEN_MAX) begin
            char_count++;
         end
         done  = last || (cap_size >= CAP_MIN && char_count == cap_size - 16'd1);
         phase = PH_IDLE;
         push_result(b, 1'b1, done);
         if (done) begin
            finish_string(last);
         end
      endfunction

      function void decode_byte(req_type r);
         logic [7:0] c;
         bit         last;
         c    = r.in_byte;
         last = r.in_last;
         bytes_taken++;
         if (skipping) begin
            if (last) begin
               skipping = 1'b0;
            end
            return;
         end
         if (c == CHAR_NUL) begin
            push_result(8'h00, 1'b0, 1'b1);
            finish_string(last);
            return;
         end
         case (phase)
            PH_IDLE: begin
               if (c == CHAR_PCT) begin
                  phase = PH_PCT;
               end else begin
                  emit_char(c, last);
                  return;
               end
            end
            PH_PCT: begin
               if (c == CHAR_TWO) begin
                  phase = PH_TWO;
               end else begin
                  high_digit = digit_value(c);
                  phase      = PH_LO;
               end
            end
            PH_TWO: begin
               if (c == CHAR_FIVE) begin
                  phase = PH_HI;
               end else begin
                  // the '2' was the high digit after all
                  high_digit = digit_value(CHAR_TWO);
                  emit_char({high_digit[3:0], 4'h0} + digit_value(c), last);
                  return;
               end
            end
            PH_HI: begin
               high_digit = digit_value(c);
               phase      = PH_LO;
            end
            default: begin
               emit_char({high_digit[3:0], 4'h0} + digit_value(c), last);
               return;
            end
         endcase
         // frame closed inside an escape
         if (last) begin
            push_result(8'h00, 1'b0, 1'b1);
            finish_string(1'b1);
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 50) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
         end
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing outstanding", got));
            return;
         end
         want = decoded_q.pop_front();
         results_checked++;
         if (want.done_res) begin
            strings_ended++;
         end
         if (got.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
         end
         if (got.byte_valid !== want.byte_valid) begin
            report_mismatch($sformatf("byte_valid %b, want %b",
                                      got.byte_valid, want.byte_valid));
         end
         if (got.done_res !== want.done_res) begin
            report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
         end
         if (got.out_length !== want.out_length) begin
            report_mismatch($sformatf("out_length %0d, want %0d",
                                      got.out_length, want.out_length));
         end
      endtask
   endclass

   decode_scoreboard sb;

   percent_decode_stream dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 37);
   end

   // outputs first: a result never belongs to the byte taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_data);
         end
         if (req_valid && !req_stall) begin
            sb.decode_byte(req_data);
         end
         if (csr_valid && csr_ready) begin
            sb.set_cap(csr_data);
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   function automatic void put(logic [7:0] b);
      req_type item;
      item.in_byte = b;
      item.in_last = 1'b0;
      url_q.push_back(item);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         put(s[i]);
      end
   endfunction

   function automatic logic [7:0] hex_char();
      int k;
      k = $urandom_range(21);
      if (k < 10) begin
         return 8'(k) + "0";
      end else if (k < 16) begin
         return 8'(k - 10) + "A";
      end else begin
         return 8'(k - 16) + "a";
      end
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (c == CHAR_PCT);
      return c;
   endfunction

   function automatic logic [15:0] pick_cap();
      case ($urandom_range(5))
         0: begin
            return 16'd0;
         end
         1: begin
            return 16'd1;
         end
         2: begin
            return 16'd2;
         end
         3: begin
            return 16'($urandom_range(3, 9));
         end
         4: begin
            return 16'hFFFF;
         end
         default: begin
            return 16'($urandom_range(65535));
         end
      endcase
   endfunction

   // mostly well-formed URL text with escapes, some noise and broken escapes
   function automatic void build_url();
      int r;
      int k;
      url_q.delete();
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 12)) put(8'($urandom_range(255)));
         return;
      end
      repeat ($urandom_range(1, 8)) begin
         r = $urandom_range(99);
         if (r < 40) begin
            put(plain_char());
         end else if (r < 65) begin
            put(CHAR_PCT);
            put(hex_char());
            put(hex_char());
         end else if (r < 77) begin
            put(CHAR_PCT);
            put(CHAR_TWO);
            put(CHAR_FIVE);
            put(hex_char());
            put(hex_char());
         end else if (r < 84) begin
            put(CHAR_PCT);
            put(CHAR_TWO);
            put(hex_char());
         end else if (r < 92) begin
            put(CHAR_PCT);
            put(8'($urandom_range(1, 255)));
            put(8'($urandom_range(1, 255)));
         end else if (r < 96) begin
            put(CHAR_NUL);
         end else begin
            put(8'($urandom_range(255)));
         end
      end
      // now and then the frame stops part way through an escape
      if ($urandom_range(99) < 15) begin
         k = $urandom_range(4);
         put(CHAR_PCT);
         if (k == 1) begin
            put(hex_char());
         end else if (k >= 2) begin
            put(CHAR_TWO);
         end
         if (k >= 3) begin
            put(CHAR_FIVE);
         end
         if (k == 4) begin
            put(hex_char());
         end
      end
   endfunction

   // all tasks below start and end on a falling edge
   task automatic push_byte(input req_type item);
      while (!calm && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      // a byte inside an escape may still be in flight with nothing outstanding
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_cap(input logic [15:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_url(input bit with_pauses);
      url_q[url_q.size() - 1].in_last = 1'b1;
      foreach (url_q[i]) begin
         push_byte(url_q[i]);
         if (with_pauses && $urandom_range(59) == 0) begin
            if ($urandom_range(1)) begin
               write_cap(pick_cap());
            end else begin
               settle();
            end
         end
      end
   endtask

   initial begin
      logic [15:0] phase_caps [PHASES];
      int          sent;
      sb = new();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // field extremes, escapes of each shape, odd digits, '%2' without '5'
      url_q.delete();
      put(8'h01);
      put(8'hFF);
      add_text("%ff%257e%20%gZ");
      send_url(1'b0);
      url_q.delete();
      add_text("%2");
      send_url(1'b0);
      url_q.delete();
      add_text("q");
      put(CHAR_NUL);
      add_text("xy");
      send_url(1'b0);
      url_q.delete();
      put(CHAR_PCT);
      put(CHAR_NUL);
      send_url(1'b0);
      write_cap(16'd3);
      url_q.delete();
      add_text("abc");
      send_url(1'b0);

      phase_caps = '{16'd0, 16'd2, 16'hFFFF, 16'd5, 16'd40, 16'd12, 16'd1};
      phase_caps[4] = 16'($urandom_range(3, 300));
      for (int p = 0; p < PHASES; p++) begin
         write_cap(phase_caps[p]);
         calm <= (p == 3);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_url();
            sent += url_q.size();
            send_url(1'b1);
         end
      end
      calm <= 1'b0;
      settle();
      repeat (10) @(negedge clock);

      if (sb.pending() != 0) begin
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
      end
      $display("Covered %0d bytes in, %0d results checked, %0d decoded strings ended",
               sb.bytes_taken, sb.results_checked, sb.strings_ended);
      $display("Cap register written %0d times, some of them part way through a string",
               sb.caps_written);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
